// ===== sv/smp_pkg.sv =====
package smp_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned CellsW = 10;
  localparam int unsigned StepW  = 29;
  localparam int unsigned ViscW  = 23;
  localparam int unsigned CfgW   = 29;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 9 * ValW;

  localparam logic [CfgIdxW-1:0] RegCellsX   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCellsY   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTimeStep = 2'd2;
  localparam logic [CfgIdxW-1:0] RegVisc     = 2'd3;

  localparam logic [CellsW-1:0] CellsRst = 10'd64;
  localparam logic [StepW-1:0]  StepRst  = 29'd4294967;
  localparam logic [ViscW-1:0]  ViscRst  = 23'd655;

  typedef logic signed [ValW-1:0] val_t;

endpackage

// ===== sv/staggered_momentum_predictor.sv =====
// Explicit momentum predictor for one staggered-grid face: takes a centre
// velocity, its four same-component neighbors and four cross-component values
// (Q16.16) and returns centre + dt*(diffusion - advection), saturated, with a
// flag when clipped. Seven-stage pipeline: one item per cycle while the output
// is taken. Each stage moves on when it is empty or the stage after it moves,
// so bubbles close up and the input side keeps taking items until every stage
// holds one and the output is not taken. Registers must be written only while
// no item is in flight; the block itself does not enforce it. The squared cell
// counts are registered and follow in the cycle after the cell counts change.
module staggered_momentum_predictor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [smp_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // centre, west, east, south, north, cross first..fourth, 32 bits each
  input  logic [smp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind (0: u, 1: v)
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tentative_value
  output logic [smp_pkg::ValW-1:0]      m_axis_tdata_o,
  // saturated
  output logic                          m_axis_tuser_o
);
  import smp_pkg::*;

  // configuration
  logic [CellsW-1:0]   cells_x_q, cells_y_q;
  logic [StepW-1:0]    step_q;
  logic [ViscW-1:0]    visc_q;
  logic [2*CellsW-1:0] cx_sq_q, cy_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CellsRst;
      cells_y_q <= CellsRst;
      step_q    <= StepRst;
      visc_q    <= ViscRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCellsX:   cells_x_q <= cfg_data_i[CellsW-1:0];
        RegCellsY:   cells_y_q <= cfg_data_i[CellsW-1:0];
        RegTimeStep: step_q    <= cfg_data_i[StepW-1:0];
        RegVisc:     visc_q    <= cfg_data_i[ViscW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cx_sq_q <= cells_x_q * cells_x_q;
    cy_sq_q <= cells_y_q * cells_y_q;
  end

  // valid bits and stage enables
  logic [7:1] vld_q;
  logic [7:1] en;

  always_comb begin
    en[7] = !vld_q[7] || m_axis_tready_i;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= s_axis_tvalid_i;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: differences and cross mean
  val_t c_in, w_in, e_in, s_in, n_in;
  logic signed [ValW+1:0] xsum, xsum_r;
  logic signed [ValW+1:0] d2x_d, d2y_d;
  logic signed [ValW:0]   dx_d, dy_d;
  val_t mean;

  assign c_in = s_axis_tdata_i[0*ValW +: ValW];
  assign w_in = s_axis_tdata_i[1*ValW +: ValW];
  assign e_in = s_axis_tdata_i[2*ValW +: ValW];
  assign s_in = s_axis_tdata_i[3*ValW +: ValW];
  assign n_in = s_axis_tdata_i[4*ValW +: ValW];

  always_comb begin
    xsum = (ValW+2)'($signed(s_axis_tdata_i[5*ValW +: ValW]))
         + (ValW+2)'($signed(s_axis_tdata_i[6*ValW +: ValW]))
         + (ValW+2)'($signed(s_axis_tdata_i[7*ValW +: ValW]))
         + (ValW+2)'($signed(s_axis_tdata_i[8*ValW +: ValW]));
    xsum_r = xsum + (ValW+2)'(2);
    mean   = xsum_r[ValW+1:2];
    d2x_d  = (ValW+2)'(w_in) - ((ValW+2)'(c_in) <<< 1) + (ValW+2)'(e_in);
    d2y_d  = (ValW+2)'(s_in) - ((ValW+2)'(c_in) <<< 1) + (ValW+2)'(n_in);
    dx_d   = (ValW+1)'(e_in) - (ValW+1)'(w_in);
    dy_d   = (ValW+1)'(n_in) - (ValW+1)'(s_in);
  end

  val_t                   c1_q, fx1_q, fy1_q;
  logic signed [ValW+1:0] d2x1_q, d2y1_q;
  logic signed [ValW:0]   dx1_q, dy1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      c1_q   <= c_in;
      fx1_q  <= s_axis_tuser_i ? mean : c_in;
      fy1_q  <= s_axis_tuser_i ? c_in : mean;
      d2x1_q <= d2x_d;
      d2y1_q <= d2y_d;
      dx1_q  <= dx_d;
      dy1_q  <= dy_d;
    end
  end

  // stage 2: viscosity and advection products
  localparam int unsigned PdW = ViscW + 1 + ValW + 2;   // 58
  localparam int unsigned PaW = 2 * ValW + 1;           // 65
  logic signed [PdW-1:0] pdx_d, pdy_d;
  logic signed [PaW-1:0] pax_d, pay_d;
  logic signed [ViscW:0] visc_s;

  assign visc_s = $signed({1'b0, visc_q});
  assign pdx_d  = PdW'(visc_s * d2x1_q);
  assign pdy_d  = PdW'(visc_s * d2y1_q);
  assign pax_d  = PaW'(fx1_q * dx1_q);
  assign pay_d  = PaW'(fy1_q * dy1_q);

  val_t                    c2_q;
  logic signed [PdW-1:0]   pdx2_q, pdy2_q;
  logic signed [2*ValW-1:0] pax2_q, pay2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c2_q   <= c1_q;
      pdx2_q <= pdx_d;
      pdy2_q <= pdy_d;
      pax2_q <= pax_d[2*ValW-1:0];   // magnitude stays below 2^63
      pay2_q <= pay_d[2*ValW-1:0];
    end
  end

  // stage 3: round to Q16.16 (advection also halved)
  localparam int unsigned RdW = PdW - 16;               // 42
  localparam int unsigned RaW = 2 * ValW - 17;          // 47
  logic signed [PdW-1:0]    rdx_s, rdy_s;
  logic signed [2*ValW-1:0] rax_s, ray_s;

  assign rdx_s = pdx2_q + PdW'(1 << 15);
  assign rdy_s = pdy2_q + PdW'(1 << 15);
  assign rax_s = pax2_q + (2*ValW)'(1 << 16);
  assign ray_s = pay2_q + (2*ValW)'(1 << 16);

  val_t                  c3_q;
  logic signed [RdW-1:0] rdx3_q, rdy3_q;
  logic signed [RaW-1:0] rax3_q, ray3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      c3_q   <= c2_q;
      rdx3_q <= rdx_s[PdW-1:16];
      rdy3_q <= rdy_s[PdW-1:16];
      rax3_q <= rax_s[2*ValW-1:17];
      ray3_q <= ray_s[2*ValW-1:17];
    end
  end

  // stage 4: scale by inverse spacing
  localparam int unsigned SdW = RdW + 2 * CellsW + 1;   // 63
  localparam int unsigned SaW = RaW + CellsW + 1;       // 58
  logic signed [SdW-1:0] sdx_d, sdy_d;
  logic signed [SaW-1:0] sax_d, say_d;

  assign sdx_d = SdW'(rdx3_q * $signed({1'b0, cx_sq_q}));
  assign sdy_d = SdW'(rdy3_q * $signed({1'b0, cy_sq_q}));
  assign sax_d = SaW'(rax3_q * $signed({1'b0, cells_x_q}));
  assign say_d = SaW'(ray3_q * $signed({1'b0, cells_y_q}));

  val_t                  c4_q;
  logic signed [SdW-1:0] sdx4_q, sdy4_q;
  logic signed [SaW-1:0] sax4_q, say4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      c4_q   <= c3_q;
      sdx4_q <= sdx_d;
      sdy4_q <= sdy_d;
      sax4_q <= sax_d;
      say4_q <= say_d;
    end
  end

  // stage 5: diffusion minus advection
  logic signed [2*ValW-1:0] total_d;

  assign total_d = (2*ValW)'(sdx4_q) + (2*ValW)'(sdy4_q)
                 - (2*ValW)'(sax4_q) - (2*ValW)'(say4_q);

  val_t                     c5_q;
  logic signed [2*ValW-1:0] total5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      c5_q     <= c4_q;
      total5_q <= total_d;
    end
  end

  // stage 6: time step times total, split in high and low words
  localparam int unsigned PhW = StepW + 1 + ValW;       // 62
  localparam int unsigned PlW = StepW + ValW;           // 61
  val_t              hi_w;
  logic [ValW-1:0]   lo_w;
  logic signed [PhW-1:0] phi_d;
  logic [PlW-1:0]    plo_d;

  assign hi_w  = total5_q[2*ValW-1:ValW];
  assign lo_w  = total5_q[ValW-1:0];
  assign phi_d = PhW'($signed({1'b0, step_q}) * hi_w);
  assign plo_d = PlW'(step_q * lo_w);

  val_t                  c6_q;
  logic signed [PhW-1:0] phi6_q;
  logic [PlW-1:0]        plo6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      c6_q   <= c5_q;
      phi6_q <= phi_d;
      plo6_q <= plo_d;
    end
  end

  // stage 7: round, add centre, saturate
  logic [PlW:0]             plo_r;
  logic signed [2*ValW-1:0] res;
  logic                     ovf_hi, ovf_lo;
  val_t                     out_d;

  always_comb begin
    plo_r  = (PlW+1)'(plo6_q) + (PlW+1)'(64'h8000_0000);
    res    = (2*ValW)'(phi6_q) + (2*ValW)'(c6_q)
           + $signed((2*ValW)'(plo_r[PlW:ValW]));
    ovf_hi = res > (2*ValW)'(64'sh0000_0000_7FFF_FFFF);
    ovf_lo = res < -(2*ValW)'(64'sh0000_0000_8000_0000);
    if (ovf_hi) begin
      out_d = val_t'(32'h7FFF_FFFF);
    end else if (ovf_lo) begin
      out_d = val_t'(32'h8000_0000);
    end else begin
      out_d = res[ValW-1:0];
    end
  end

  val_t out_q;
  logic sat_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      out_q <= out_d;
      sat_q <= ovf_hi || ovf_lo;
    end
  end

  assign m_axis_tvalid_o = vld_q[7];
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = sat_q;

  // a clipped result sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o == 32'h7FFF_FFFF || m_axis_tdata_o == 32'h8000_0000)
    else $error("saturation flag without clipped value");

  // the input side only stalls when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i && (&vld_q))
    else $error("input stalled with room in the pipeline");

  // an item taken at the output leaves, unless a new one follows behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !vld_q[6] |=> !m_axis_tvalid_o)
    else $error("output item repeated");

endmodule
